// ===== hw/rtl/kdlp_pkg.sv =====
// kdlp_pkg: shared types and constants of the keypad debounce / long-press unit.
// Used by kdlp_lane, kdlp_merge and keypad_debounce_long_press_unit; no dependencies.
package kdlp_pkg;

    // Width of the key level input and of the polarity register
    localparam int IN_KEYS = 5;
    localparam int KEY_ID_W = 3;
    localparam int KIND_W = 2;
    localparam int STAMP_W = 32;
    localparam int TIME_W = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register index codes (byte address = 4 * index)
    localparam logic [1:0] REG_ACTIVE_MASK = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS = 2'd2;

    localparam logic [IN_KEYS-1:0] ACTIVE_MASK_RST = 5'd30;
    localparam logic [TIME_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 16'd1000;

    typedef enum logic [KIND_W-1:0] {
        EV_PRESSED = 2'd0,
        EV_RELEASED = 2'd1,
        EV_LONG = 2'd2
    } ev_kind_t;

    // One lane's finding for the current poll
    typedef struct packed {
        logic fire;
        ev_kind_t kind;
    } key_event_t;

    // Merge stage status seen by the top level
    typedef struct packed {
        logic pend_any;
        logic pend_multi;
    } merge_status_t;

endpackage

// ===== hw/rtl/kdlp_lane.sv =====
// kdlp_lane: per-key phase machine with time stamp; reports at most one event per poll.
// Depends on kdlp_pkg.
module kdlp_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  take,
    input  logic                                  level,
    input  logic                                  active,
    input  logic [kdlp_pkg::STAMP_W-1:0]          now_ms,
    input  logic [kdlp_pkg::TIME_W-1:0]           debounce_ms,
    input  logic [kdlp_pkg::TIME_W-1:0]           long_press_ms,
    output kdlp_pkg::key_event_t                  ev
);

    typedef enum logic [3:0] {
        PH_RELEASED = 4'b0001,
        PH_PREPRESS = 4'b0010,
        PH_PRESSED  = 4'b0100,
        PH_LONG     = 4'b1000
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [kdlp_pkg::STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [kdlp_pkg::STAMP_W-1:0]  elapsed;
    logic                          pressed;
    logic                          over_db;
    logic                          over_lp;

    assign pressed = (level == active);
    // wraparound difference
    assign elapsed = now_ms - stamp_reg;
    assign over_db = elapsed > {{(kdlp_pkg::STAMP_W-kdlp_pkg::TIME_W){1'b0}}, debounce_ms};
    assign over_lp = elapsed > {{(kdlp_pkg::STAMP_W-kdlp_pkg::TIME_W){1'b0}}, long_press_ms};

    always_comb begin
        phase_next = phase_reg;
        stamp_next = stamp_reg;
        ev.fire = 1'b0;
        ev.kind = kdlp_pkg::EV_PRESSED;
        case (phase_reg)
            PH_RELEASED: begin
                if (pressed) begin
                    phase_next = PH_PREPRESS;
                    stamp_next = now_ms;
                end
            end
            PH_PREPRESS: begin
                // bounce back: no event, stamp kept
                if (!pressed) begin
                    phase_next = PH_RELEASED;
                end else if (over_db) begin
                    phase_next = PH_PRESSED;
                    stamp_next = now_ms;
                    ev.fire = 1'b1;
                    ev.kind = kdlp_pkg::EV_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    phase_next = PH_RELEASED;
                    stamp_next = '0;
                    ev.fire = 1'b1;
                    ev.kind = kdlp_pkg::EV_RELEASED;
                end else if (over_lp) begin
                    phase_next = PH_LONG;
                    stamp_next = now_ms;
                    ev.fire = 1'b1;
                    ev.kind = kdlp_pkg::EV_LONG;
                end
            end
            PH_LONG: begin
                if (!pressed) begin
                    phase_next = PH_RELEASED;
                    stamp_next = '0;
                    ev.fire = 1'b1;
                    ev.kind = kdlp_pkg::EV_RELEASED;
                end
            end
            default: begin
                phase_next = PH_RELEASED;
                stamp_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RELEASED;
            stamp_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            stamp_reg <= stamp_next;
        end
    end

endmodule

// ===== hw/rtl/kdlp_merge.sv =====
// kdlp_merge: holds one poll's lane events and sends them out lowest key first.
// Depends on kdlp_pkg.
module kdlp_merge #(
    parameter int NUM_KEYS = 5
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  kdlp_pkg::key_event_t                  lane_ev [NUM_KEYS],
    output logic                                  can_load,
    output kdlp_pkg::merge_status_t               status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [kdlp_pkg::KEY_ID_W-1:0]         m_key_id,
    output logic [kdlp_pkg::KIND_W-1:0]           m_event_kind,
    output logic                                  m_last_event
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [NUM_KEYS-1:0]           pend_reg, pend_next;
    kdlp_pkg::ev_kind_t            kind_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0]           sel_onehot;
    logic [NUM_KEYS-1:0]           rest;
    logic [IDX_W-1:0]              sel;
    logic                          out_free;
    logic                          move_out;

    logic                          m_valid_reg;
    logic [kdlp_pkg::KEY_ID_W-1:0] key_id_reg;
    kdlp_pkg::ev_kind_t            kind_out_reg;
    logic                          last_reg;

    // lowest pending key wins
    always_comb begin
        sel = '0;
        sel_onehot = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = IDX_W'(i);
                sel_onehot = NUM_KEYS'(1) << i;
            end
        end
    end

    assign rest = pend_reg & ~sel_onehot;
    assign out_free = !m_valid_reg || m_ready;
    assign move_out = out_free && (|pend_reg);
    // a new poll may enter once the previous one's last event moves to the output
    assign can_load = !(|pend_reg) || (move_out && !(|rest));

    assign status.pend_any = |pend_reg;
    assign status.pend_multi = |rest;

    always_comb begin
        pend_next = pend_reg;
        if (move_out) begin
            pend_next = rest;
        end
        if (load) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                pend_next[i] = lane_ev[i].fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (move_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                kind_reg[i] <= lane_ev[i].kind;
            end
        end
        if (move_out) begin
            key_id_reg <= kdlp_pkg::KEY_ID_W'(sel);
            kind_out_reg <= kind_reg[sel];
            last_reg <= !(|rest);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_key_id = key_id_reg;
    assign m_event_kind = kind_out_reg;
    assign m_last_event = last_reg;

endmodule

// ===== hw/rtl/keypad_debounce_long_press_unit.sv =====
// Keypad debounce / long-press unit: one lane per key plus an event merge stage.
// A poll of raw key levels and a millisecond timestamp updates every key in the cycle
// it is accepted; the lanes' events go into the merge stage, which sends them one per
// cycle when not stalled by m_ready, in key order, with the last mark on the final one.
// The next poll is taken in the cycle the previous poll's last event moves into the
// output register, so the single-event output port sets the rate. Registers (APB,
// byte address 4*i): active_mask, debounce_ms, long_press_ms. Write them only while
// no transaction is in flight.
module keypad_debounce_long_press_unit #(
    parameter int NUM_KEYS = 5
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [kdlp_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [kdlp_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [kdlp_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [kdlp_pkg::IN_KEYS-1:0]          s_key_levels,
    input  logic [kdlp_pkg::STAMP_W-1:0]          s_now_ms,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [kdlp_pkg::KEY_ID_W-1:0]         m_key_id,
    output logic [kdlp_pkg::KIND_W-1:0]           m_event_kind,
    output logic                                  m_last_event
);

    logic [kdlp_pkg::IN_KEYS-1:0] active_mask_reg;
    logic [kdlp_pkg::TIME_W-1:0]  debounce_reg;
    logic [kdlp_pkg::TIME_W-1:0]  long_press_reg;
    logic [1:0]                   reg_idx;
    logic                         cfg_wr;
    logic                         take;
    logic                         can_load;
    kdlp_pkg::merge_status_t      status;
    kdlp_pkg::key_event_t         lane_ev [NUM_KEYS];

    assign pready = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_mask_reg <= kdlp_pkg::ACTIVE_MASK_RST;
            debounce_reg <= kdlp_pkg::DEBOUNCE_RST;
            long_press_reg <= kdlp_pkg::LONG_PRESS_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                kdlp_pkg::REG_ACTIVE_MASK: active_mask_reg <= pwdata[kdlp_pkg::IN_KEYS-1:0];
                kdlp_pkg::REG_DEBOUNCE:    debounce_reg <= pwdata[kdlp_pkg::TIME_W-1:0];
                kdlp_pkg::REG_LONG_PRESS:  long_press_reg <= pwdata[kdlp_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            kdlp_pkg::REG_ACTIVE_MASK: prdata = kdlp_pkg::APB_DATA_W'(active_mask_reg);
            kdlp_pkg::REG_DEBOUNCE:    prdata = kdlp_pkg::APB_DATA_W'(debounce_reg);
            kdlp_pkg::REG_LONG_PRESS:  prdata = kdlp_pkg::APB_DATA_W'(long_press_reg);
            default:                   prdata = '0;
        endcase
    end

    assign s_ready = can_load;
    assign take = s_valid && can_load;

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        logic lvl;
        logic act;
        // keys beyond the input word read level 0 with low-active polarity
        if (g < kdlp_pkg::IN_KEYS) begin : g_in
            assign lvl = s_key_levels[g];
            assign act = active_mask_reg[g];
        end else begin : g_pad
            assign lvl = 1'b0;
            assign act = 1'b0;
        end

        kdlp_lane u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .take          (take),
            .level         (lvl),
            .active        (act),
            .now_ms        (s_now_ms),
            .debounce_ms   (debounce_reg),
            .long_press_ms (long_press_reg),
            .ev            (lane_ev[g])
        );
    end

    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (take),
        .lane_ev      (lane_ev),
        .can_load     (can_load),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_id     (m_key_id),
        .m_event_kind (m_event_kind),
        .m_last_event (m_last_event)
    );

`ifndef NO_ASSERTIONS
    // never take a poll while the previous one still has two or more events queued
    a_ready_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.pend_multi)
        else $error("poll accepted with events still queued");

    // a queued event reaches an empty output register in the next cycle
    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.pend_any && !m_valid) |=> m_valid)
        else $error("queued event not moved to output");

    // an event without the last mark is followed by more of the same poll
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_event) |-> status.pend_any)
        else $error("non-last event with nothing queued behind it");
`endif

endmodule
